>>> rtl/pwc_pkg.sv
package pwc_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE   = 3'd0,
        KIND_TICK    = 3'd1,
        KIND_QUARTER = 3'd2,
        KIND_HALF    = 3'd3,
        KIND_ENABLE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_VOLUME     = 2'd0,
        REG_SWEEP      = 2'd1,
        REG_TIMER_LOW  = 2'd2,
        REG_TIMER_HIGH = 2'd3
    } reg_index_t;

    localparam int unsigned DIVIDER_W     = 6;
    localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 6'd2;
    localparam int unsigned TIMER_W       = 11;
    localparam int unsigned PERIOD_W      = 17;
    localparam int unsigned LEVEL_W       = 5;
    localparam logic [3:0]  ENV_FULL      = 4'd15;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      length_active;
    } result_t;

    function automatic logic [7:0] length_lookup(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'h0a;
            5'd1:  v = 8'hfe;
            5'd2:  v = 8'h14;
            5'd3:  v = 8'h02;
            5'd4:  v = 8'h28;
            5'd5:  v = 8'h04;
            5'd6:  v = 8'h50;
            5'd7:  v = 8'h06;
            5'd8:  v = 8'ha0;
            5'd9:  v = 8'h08;
            5'd10: v = 8'h3c;
            5'd11: v = 8'h0a;
            5'd12: v = 8'h0e;
            5'd13: v = 8'h0c;
            5'd14: v = 8'h1a;
            5'd15: v = 8'h0e;
            5'd16: v = 8'h0c;
            5'd17: v = 8'h10;
            5'd18: v = 8'h18;
            5'd19: v = 8'h12;
            5'd20: v = 8'h30;
            5'd21: v = 8'h14;
            5'd22: v = 8'h60;
            5'd23: v = 8'h16;
            5'd24: v = 8'hc0;
            5'd25: v = 8'h18;
            5'd26: v = 8'h48;
            5'd27: v = 8'h1a;
            5'd28: v = 8'h10;
            5'd29: v = 8'h1c;
            5'd30: v = 8'h20;
            default: v = 8'h1e;
        endcase
        return v;
    endfunction

    // bit n of the pattern is the output at duty position n
    function automatic logic duty_high(input logic [1:0] mode, input logic [2:0] step);
        logic [7:0] pattern;
        case (mode)
            2'd0:    pattern = 8'b0000_0010;
            2'd1:    pattern = 8'b0000_0110;
            2'd2:    pattern = 8'b0001_1110;
            default: pattern = 8'b1111_1001;
        endcase
        return pattern[step];
    endfunction

endpackage

>>> rtl/pwc_core.sv
module pwc_core
    import pwc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [DIVIDER_W-1:0] cfg_wdata,
    input  logic                 req_accept,
    input  logic [2:0]           req_kind,
    input  logic [1:0]           req_index,
    input  logic [7:0]           req_value,
    input  logic                 req_enable,
    output result_t              result
);

    logic [DIVIDER_W-1:0] divider_reg;
    logic [1:0]           duty_mode_reg,       duty_mode_next;
    logic                 loop_flag_reg,       loop_flag_next;
    logic                 constant_flag_reg,   constant_flag_next;
    logic [3:0]           env_period_reg,      env_period_next;
    logic [TIMER_W-1:0]   timer_value_reg,     timer_value_next;
    logic [PERIOD_W-1:0]  reload_period_reg,   reload_period_next;
    logic [PERIOD_W-1:0]  countdown_reg,       countdown_next;
    logic [2:0]           duty_step_reg,       duty_step_next;
    logic [7:0]           length_count_reg,    length_count_next;
    logic                 halted_reg,          halted_next;
    logic [3:0]           env_divider_reg,     env_divider_next;
    logic [3:0]           env_counter_reg,     env_counter_next;
    logic [3:0]           volume_reg,          volume_next;
    logic [LEVEL_W-1:0]   level_reg,           level_next;

    logic [TIMER_W-1:0]               timer_written;
    logic [TIMER_W:0]                 timer_plus_one;
    logic [TIMER_W+DIVIDER_W:0]       period_product;
    logic [LEVEL_W-1:0]               vol_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg <= DIVIDER_RESET;
        end else if (cfg_wen) begin
            divider_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_mode_reg     <= '0;
            loop_flag_reg     <= 1'b0;
            constant_flag_reg <= 1'b0;
            env_period_reg    <= '0;
            timer_value_reg   <= '0;
            reload_period_reg <= '0;
            countdown_reg     <= '0;
            duty_step_reg     <= '0;
            length_count_reg  <= '0;
            halted_reg        <= 1'b1;
            env_divider_reg   <= '0;
            env_counter_reg   <= '0;
            volume_reg        <= '0;
            level_reg         <= '0;
        end else if (req_accept) begin
            duty_mode_reg     <= duty_mode_next;
            loop_flag_reg     <= loop_flag_next;
            constant_flag_reg <= constant_flag_next;
            env_period_reg    <= env_period_next;
            timer_value_reg   <= timer_value_next;
            reload_period_reg <= reload_period_next;
            countdown_reg     <= countdown_next;
            duty_step_reg     <= duty_step_next;
            length_count_reg  <= length_count_next;
            halted_reg        <= halted_next;
            env_divider_reg   <= env_divider_next;
            env_counter_reg   <= env_counter_next;
            volume_reg        <= volume_next;
            level_reg         <= level_next;
        end
    end

    // period follows the timer value as written by this request
    assign timer_written  = (reg_index_t'(req_index) == REG_TIMER_HIGH)
                          ? {req_value[2:0], timer_value_reg[7:0]}
                          : {timer_value_reg[10:8], req_value};
    assign timer_plus_one = {1'b0, timer_written} + {{TIMER_W{1'b0}}, 1'b1};
    assign period_product = timer_plus_one * divider_reg;
    assign vol_wide       = {1'b0, volume_reg};

    always_comb begin
        duty_mode_next     = duty_mode_reg;
        loop_flag_next     = loop_flag_reg;
        constant_flag_next = constant_flag_reg;
        env_period_next    = env_period_reg;
        timer_value_next   = timer_value_reg;
        reload_period_next = reload_period_reg;
        countdown_next     = countdown_reg;
        duty_step_next     = duty_step_reg;
        length_count_next  = length_count_reg;
        halted_next        = halted_reg;
        env_divider_next   = env_divider_reg;
        env_counter_next   = env_counter_reg;
        volume_next        = volume_reg;
        level_next         = level_reg;

        case (kind_t'(req_kind))
            KIND_WRITE: begin
                case (reg_index_t'(req_index))
                    REG_VOLUME: begin
                        duty_mode_next     = req_value[7:6];
                        loop_flag_next     = req_value[5];
                        constant_flag_next = req_value[4];
                        env_period_next    = req_value[3:0];
                    end
                    REG_TIMER_LOW: begin
                        timer_value_next   = timer_written;
                        reload_period_next = period_product[PERIOD_W-1:0];
                    end
                    REG_TIMER_HIGH: begin
                        timer_value_next   = timer_written;
                        reload_period_next = period_product[PERIOD_W-1:0];
                        if (timer_written[10:3] == 8'd0) begin
                            level_next        = '0;
                            length_count_next = '0;
                            halted_next       = 1'b1;
                        end else begin
                            length_count_next = length_lookup(req_value[7:3]);
                            countdown_next    = period_product[PERIOD_W-1:0];
                            duty_step_next    = '0;
                            env_counter_next  = ENV_FULL;
                            env_divider_next  = env_period_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_TICK: begin
                if (reload_period_reg != '0) begin
                    if (countdown_reg == '0) begin
                        countdown_next = reload_period_reg - 1'b1;
                        if (length_count_reg != '0) begin
                            duty_step_next = duty_step_reg + 1'b1;
                        end
                    end else begin
                        countdown_next = countdown_reg - 1'b1;
                    end
                    if (halted_reg) begin
                        level_next = '0;
                    end else if (duty_high(duty_mode_reg, duty_step_next)) begin
                        level_next = vol_wide;
                    end else begin
                        level_next = -vol_wide;
                    end
                end
            end
            KIND_QUARTER: begin
                if (env_divider_reg == '0) begin
                    env_divider_next = env_period_reg;
                    if (env_counter_reg != '0) begin
                        env_counter_next = env_counter_reg - 1'b1;
                    end else if (loop_flag_reg) begin
                        env_counter_next = ENV_FULL;
                    end
                    volume_next = constant_flag_reg ? env_period_reg : env_counter_next;
                end else begin
                    env_divider_next = env_divider_reg - 1'b1;
                end
            end
            KIND_HALF: begin
                if (!loop_flag_reg && length_count_reg != '0) begin
                    length_count_next = length_count_reg - 1'b1;
                    if (length_count_next == '0) begin
                        volume_next = '0;
                    end
                end
            end
            KIND_ENABLE: begin
                halted_next = !req_enable;
                if (!req_enable) begin
                    level_next        = '0;
                    length_count_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign result.level         = level_next;
    assign result.length_active = (length_count_next != '0);

endmodule

>>> rtl/pwc_out_buf.sv
module pwc_out_buf
    import pwc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    has_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t head_reg, head_next;
    result_t tail_reg, tail_next;
    logic    head_valid_reg, head_valid_next;
    logic    tail_valid_reg, tail_valid_next;
    logic    pop;

    assign pop       = head_valid_reg && out_ready;
    assign has_room  = !tail_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (pop) begin
            if (tail_valid_reg) begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end else begin
                head_valid_next = 1'b0;
            end
            if (push) begin
                if (tail_valid_reg) begin
                    tail_next       = push_data;
                    tail_valid_next = 1'b1;
                end else begin
                    head_next       = push_data;
                    head_valid_next = 1'b1;
                end
            end
        end else if (push) begin
            if (head_valid_reg) begin
                tail_next       = push_data;
                tail_valid_next = 1'b1;
            end else begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> rtl/pulse_wave_channel_top.sv
// pulse wave channel: square-wave sound channel with envelope and length counter
//
// s_ channel takes one request per cycle while s_tready is high: a register
// write, timer tick, quarter frame, half frame or enable, with the kind in s_tuser.
// m_ channel returns exactly one result per request: the signed output level
// and whether the length counter is running.
// cfg_wen / cfg_wdata set the clock divider; write only while idle.
//
// a result is registered in the output buffer before it appears on m_tdata.
// throughput: one request per cycle while s_tready is high; channel state is
// updated in a single pass of logic between the request and the result register.
// a two-entry output buffer lets the next request in while a result waits;
// when the receiver stalls, s_tready drops once both entries are full.
// reset: synchronous, active low; channel halted, level 0, divider 2,
// output buffer empty.
module pulse_wave_channel_top
    import pwc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [DIVIDER_W-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,  // reg_index[1:0], reg_value[9:2], enable_bit[10]
    input  logic [2:0]           s_tuser,  // kind[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata   // level[4:0], length_active[5]
);

    logic    req_accept;
    result_t core_result;
    result_t out_result;

    assign req_accept = s_tvalid && s_tready;

    pwc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .req_accept (req_accept),
        .req_kind   (s_tuser),
        .req_index  (s_tdata[1:0]),
        .req_value  (s_tdata[9:2]),
        .req_enable (s_tdata[10]),
        .result     (core_result)
    );

    pwc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (req_accept),
        .push_data (core_result),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {2'b00, out_result.length_active, out_result.level};

endmodule

>>> test/pulse_wave_channel_top_tb.sv
`timescale 1ns / 1ps

module pulse_wave_channel_top_tb;
    import pwc_pkg::*;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam logic [7:0] LENGTH_LOAD [32] = '{
        8'h0a, 8'hfe, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
        8'ha0, 8'h08, 8'h3c, 8'h0a, 8'h0e, 8'h0c, 8'h1a, 8'h0e,
        8'h0c, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
        8'hc0, 8'h18, 8'h48, 8'h1a, 8'h10, 8'h1c, 8'h20, 8'h1e
    };

    // bit n is the wave at duty position n
    localparam logic [7:0] DUTY_WAVE [4] = '{
        8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [DIVIDER_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;

    pulse_wave_channel_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // channel state as the block should hold it
    logic [DIVIDER_W-1:0] ch_divider;
    logic [1:0]           ch_duty;
    logic                 ch_loop;
    logic                 ch_const;
    logic [3:0]           ch_env_period;
    logic [TIMER_W-1:0]   ch_timer;
    logic [PERIOD_W-1:0]  ch_reload;
    logic [PERIOD_W-1:0]  ch_countdown;
    logic [2:0]           ch_step;
    logic [7:0]           ch_length;
    logic                 ch_halted;
    logic [3:0]           ch_env_div;
    logic [3:0]           ch_env_count;
    logic [3:0]           ch_volume;
    logic [LEVEL_W-1:0]   ch_level;

    result_t expected_levels [$];
    int      mismatches = 0;
    int      requests_sent = 0;
    int      results_seen = 0;
    int      divider_settings = 0;
    bit      steady = 1'b0;

    function automatic logic [PERIOD_W-1:0] reload_for_timer();
        int unsigned prod;
        prod = (int'(ch_timer) + 1) * int'(ch_divider);
        return prod[PERIOD_W-1:0];
    endfunction

    function automatic void mute_channel();
        ch_level  = '0;
        ch_length = '0;
        ch_halted = 1'b1;
    endfunction

    function automatic result_t next_channel_output(input logic [2:0] kind,
                                                    input logic [1:0] idx,
                                                    input logic [7:0] val,
                                                    input logic en);
        result_t r;
        case (kind)
            KIND_WRITE: begin
                case (idx)
                    REG_VOLUME: begin
                        ch_duty       = val[7:6];
                        ch_loop       = val[5];
                        ch_const      = val[4];
                        ch_env_period = val[3:0];
                    end
                    REG_TIMER_LOW: begin
                        ch_timer[7:0] = val;
                        ch_reload     = reload_for_timer();
                    end
                    REG_TIMER_HIGH: begin
                        ch_timer[10:8] = val[2:0];
                        ch_length      = LENGTH_LOAD[val[7:3]];
                        ch_reload      = reload_for_timer();
                        if (ch_timer < 8) begin
                            mute_channel();
                        end else begin
                            ch_countdown = ch_reload;
                            ch_step      = '0;
                            ch_env_count = 4'd15;
                            ch_env_div   = ch_env_period;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_TICK: begin
                if (ch_reload != 0) begin
                    if (ch_countdown == 0) begin
                        ch_countdown = ch_reload - 1'b1;
                        if (ch_length != 0) begin
                            ch_step = ch_step + 1'b1;
                        end
                    end else begin
                        ch_countdown = ch_countdown - 1'b1;
                    end
                    if (ch_halted) begin
                        ch_level = '0;
                    end else if (DUTY_WAVE[ch_duty][ch_step]) begin
                        ch_level = {1'b0, ch_volume};
                    end else begin
                        ch_level = 5'd0 - {1'b0, ch_volume};
                    end
                end
            end
            KIND_QUARTER: begin
                if (ch_env_div == 0) begin
                    ch_env_div = ch_env_period;
                    if (ch_env_count != 0) begin
                        ch_env_count = ch_env_count - 1'b1;
                    end else if (ch_loop) begin
                        ch_env_count = 4'd15;
                    end
                    ch_volume = ch_const ? ch_env_period : ch_env_count;
                end else begin
                    ch_env_div = ch_env_div - 1'b1;
                end
            end
            KIND_HALF: begin
                if (!ch_loop && ch_length != 0) begin
                    ch_length = ch_length - 1'b1;
                    if (ch_length == 0) begin
                        ch_volume = '0;
                    end
                end
            end
            KIND_ENABLE: begin
                if (!en) begin
                    mute_channel();
                end
                ch_halted = !en;
            end
            default: ;
        endcase
        r.level         = ch_level;
        r.length_active = (ch_length != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_request(input logic [2:0] kind, input logic [1:0] idx,
                                input logic [7:0] val, input logic en);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, en, val, idx};
        expected_levels.push_back(next_channel_output(kind, idx, val, en));
        requests_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_divider(input logic [DIVIDER_W-1:0] d);
        pause_until_drained();
        cfg_wdata <= d;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen    <= 1'b0;
        ch_divider = d;
        divider_settings++;
    endtask

    // result checker
    initial begin
        int      stall;
        result_t want;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            results_seen++;
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected result, level", $signed(m_tdata[4:0]), 0);
            end else begin
                want = expected_levels.pop_front();
                if (m_tdata[4:0] !== want.level) begin
                    report_mismatch("level", $signed(m_tdata[4:0]), want.level);
                end
                if (m_tdata[5] !== want.length_active) begin
                    report_mismatch("length_active", m_tdata[5], want.length_active);
                end
            end
        end
    end

    task automatic test_directed();
        steady = 1'b0;
        // untouched channel: no period yet, halted
        send_request(KIND_TICK, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_QUARTER, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_HALF, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_ENABLE, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_SPARE_FIRST, REG_TIMER_HIGH, 8'hff, 1'b1);
        send_request(KIND_WRITE, REG_VOLUME, 8'hff, 1'b0);
        send_request(KIND_WRITE, REG_SWEEP, 8'hff, 1'b1);
        send_request(KIND_WRITE, REG_TIMER_LOW, 8'hff, 1'b0);
        send_request(KIND_WRITE, REG_TIMER_HIGH, 8'hff, 1'b0);
        send_request(KIND_ENABLE, REG_VOLUME, 8'h00, 1'b1);
        send_request(KIND_QUARTER, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_TICK, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_TICK, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_HALF, REG_VOLUME, 8'h00, 1'b0);
        // short timer mutes on the high write
        send_request(KIND_WRITE, REG_TIMER_LOW, 8'h03, 1'b0);
        send_request(KIND_WRITE, REG_TIMER_HIGH, 8'h00, 1'b0);
        send_request(KIND_TICK, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_ENABLE, REG_VOLUME, 8'h00, 1'b1);
        send_request(KIND_WRITE, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_WRITE, REG_TIMER_LOW, 8'h08, 1'b0);
        send_request(KIND_WRITE, REG_TIMER_HIGH, 8'h08, 1'b0);
        send_request(KIND_QUARTER, REG_VOLUME, 8'h00, 1'b0);
        repeat (3) send_request(KIND_TICK, REG_VOLUME, 8'h00, 1'b0);
        send_request(KIND_ENABLE, REG_TIMER_HIGH, 8'hff, 1'b0);
        send_request(KIND_SPARE_LAST, REG_TIMER_HIGH, 8'hff, 1'b1);
    endtask

    task automatic test_zero_divider();
        set_divider('0);
        send_request(KIND_ENABLE, REG_VOLUME, 8'h00, 1'b1);
        send_request(KIND_WRITE, REG_VOLUME, 8'hdf, 1'b0);
        send_request(KIND_WRITE, REG_TIMER_LOW, 8'h10, 1'b0);
        send_request(KIND_WRITE, REG_TIMER_HIGH, 8'h01, 1'b0);
        send_request(KIND_QUARTER, REG_VOLUME, 8'h00, 1'b0);
        repeat (4) send_request(KIND_TICK, REG_VOLUME, 8'h00, 1'b0);
    endtask

    task automatic send_noise();
        send_request(3'($urandom_range(0, 7)), 2'($urandom()), 8'($urandom()),
                     1'($urandom()));
    endtask

    task automatic test_random(input int n, input logic [DIVIDER_W-1:0] d);
        int  sent;
        int  burst;
        int  pick;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        set_divider(d);
        while (sent < n) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 15) begin
                send_noise();
                sent++;
            end else begin
                // program a note, then run it
                send_request(KIND_ENABLE, REG_VOLUME, 8'h00, 1'b1);
                send_request(KIND_WRITE, REG_VOLUME, 8'($urandom()), 1'b0);
                send_request(KIND_WRITE, REG_TIMER_LOW,
                             ($urandom_range(0, 9) < 7) ? 8'($urandom_range(8, 24))
                                                        : 8'($urandom()), 1'($urandom()));
                send_request(KIND_WRITE, REG_TIMER_HIGH,
                             {5'($urandom()),
                              ($urandom_range(0, 4) == 0) ? 3'($urandom()) : 3'b000},
                             1'($urandom()));
                sent += 4;
                burst = $urandom_range(10, 40);
                repeat (burst) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60) begin
                        send_request(KIND_TICK, 2'($urandom()), 8'($urandom()), 1'($urandom()));
                    end else if (pick < 75) begin
                        send_request(KIND_QUARTER, 2'($urandom()), 8'($urandom()),
                                     1'($urandom()));
                    end else if (pick < 85) begin
                        send_request(KIND_HALF, 2'($urandom()), 8'($urandom()), 1'($urandom()));
                    end else if (pick < 90) begin
                        send_request(KIND_ENABLE, 2'($urandom()), 8'($urandom()),
                                     ($urandom_range(0, 3) != 0));
                    end else if (pick < 95) begin
                        send_request(KIND_WRITE, 2'($urandom()), 8'($urandom()), 1'($urandom()));
                    end else begin
                        send_request(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                                     2'($urandom()), 8'($urandom()), 1'($urandom()));
                    end
                end
                sent += burst;
            end
            if (!paused && sent > n / 2) begin
                pause_until_drained();
                paused = 1'b1;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        ch_divider    = DIVIDER_RESET;
        ch_duty       = '0;
        ch_loop       = 1'b0;
        ch_const      = 1'b0;
        ch_env_period = '0;
        ch_timer      = '0;
        ch_reload     = '0;
        ch_countdown  = '0;
        ch_step       = '0;
        ch_length     = '0;
        ch_halted     = 1'b1;
        ch_env_div    = '0;
        ch_env_count  = '0;
        ch_volume     = '0;
        ch_level      = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed();
        test_random(500, 6'd1);
        test_random(250, 6'd63);
        test_zero_divider();
        test_random(500, DIVIDER_RESET);
        test_random(500, 6'($urandom_range(1, 63)));

        pause_until_drained();
        repeat (5) @(posedge aclk);
        $display("covered %0d requests and %0d results across %0d divider settings,",
                 requests_sent, results_seen, divider_settings);
        $display("including a zero divider, short-timer mutes and stalls on both sides");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
